/* hw/rtl/cpid_pkg.sv */
// Shared widths, register codes and inter-stage types for the clamped PID step.
package cpid_pkg;

    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int ACC_W      = 48;
    localparam int BOUND_W    = 47;
    localparam int LIM_W      = 31;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int CTRL_W     = 32;
    localparam int MOTOR_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    // integral product is split into two partial products at this bit
    localparam int ACC_SPLIT  = 24;
    localparam int PE_W       = GAIN_W + ERR_W;
    localparam int PD_W       = GAIN_W + DIFF_W;
    localparam int PLO_W      = GAIN_W + ACC_SPLIT + 1;
    localparam int PHI_W      = GAIN_W + ACC_W - ACC_SPLIT;
    localparam int SUM_W      = GAIN_W + ACC_W + 2;
    localparam int SHR_W      = SUM_W - FRAC_W;

    localparam logic [MOTOR_W-1:0] MOTOR_MAX = 16'd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_BOUND = 3'd3,
        CFG_OUT_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [BOUND_W-1:0]       integ_bound;
        logic [LIM_W-1:0]         out_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ACC_W-1:0]  acc;
        logic signed [DIFF_W-1:0] diff;
    } t_stage_b;

    typedef struct packed {
        logic signed [PE_W-1:0]  pe;
        logic signed [PD_W-1:0]  pd;
        logic signed [PLO_W-1:0] plo;
        logic signed [PHI_W-1:0] phi;
    } t_prod;

    typedef struct packed {
        logic signed [CTRL_W-1:0]  ctrl_value;
        logic signed [MOTOR_W-1:0] motor_cmd;
    } t_result;

endpackage

/* hw/rtl/cpid_in_if.sv */
// Input channel: one error sample and its clear flag per transaction.
interface cpid_in_if
    import cpid_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] err_sample;
    logic                    clear_first;

    modport source (output valid, output err_sample, output clear_first, input ready);
    modport sink   (input valid, input err_sample, input clear_first, output ready);
endinterface

/* hw/rtl/cpid_out_if.sv */
// Output channel: controller value and motor command per transaction.
interface cpid_out_if
    import cpid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [CTRL_W-1:0]  ctrl_value;
    logic signed [MOTOR_W-1:0] motor_cmd;

    modport source (output valid, output ctrl_value, output motor_cmd, input ready);
    modport sink   (input valid, input ctrl_value, input motor_cmd, output ready);
endinterface

/* hw/rtl/cpid_cfg_if.sv */
// Configuration write channel: register index and write data.
interface cpid_cfg_if
    import cpid_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/clamped_pid_step.sv */
// Top level of the clamped PID step: configuration, accumulator, multipliers, output.
//
// Usage:
//   i_cfg  - write channel; index selects prop_gain, integ_gain, deriv_gain,
//            integ_bound or out_limit (0..4). Always ready. Other indexes are
//            ignored. Write only while no sample is in flight.
//   i_in   - one error sample (Q16.16) plus clear_first per transaction.
//   o_out  - clamped output (Q16.16) and saturated 16-bit motor command.
// Pipeline: input register, accumulator/difference, multipliers, product
// sum, clamp/output register. One sample per cycle is sustained while the
// receiver takes results, as the accumulator update that each sample needs
// from the one before it is combinational within the accumulator stage.
// Each stage has its own valid, so the block keeps taking samples into
// empty stages while the output register waits; a stalled receiver fills
// the five stages and then holds i_in.ready low.
// Reset (synchronous, active low) clears the configuration registers, the
// accumulator and the previous error, and empties the pipeline.
module clamped_pid_step
    import cpid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpid_cfg_if.sink   i_cfg,
    cpid_in_if.sink    i_in,
    cpid_out_if.source o_out
);

    t_cfg     w_cfg;
    logic     w_b_valid;
    logic     w_b_ready;
    t_stage_b w_b_data;
    logic     w_c_valid;
    logic     w_c_ready;
    t_prod    w_c_data;
    t_result  w_res;

    cpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (w_cfg)
    );

    cpid_integ u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_err      (i_in.err_sample),
        .i_clr      (i_in.clear_first),
        .o_ready    (i_in.ready),
        .i_bound    (w_cfg.integ_bound),
        .o_valid    (w_b_valid),
        .o_data     (w_b_data),
        .i_ready_dn (w_b_ready)
    );

    cpid_mult u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_b_valid),
        .i_data     (w_b_data),
        .o_ready    (w_b_ready),
        .i_cfg      (w_cfg),
        .o_valid    (w_c_valid),
        .o_data     (w_c_data),
        .i_ready_dn (w_c_ready)
    );

    cpid_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_c_valid),
        .i_data     (w_c_data),
        .o_ready    (w_c_ready),
        .i_limit    (w_cfg.out_limit),
        .o_valid    (o_out.valid),
        .o_data     (w_res),
        .i_ready_dn (o_out.ready)
    );

    assign o_out.ctrl_value = w_res.ctrl_value;
    assign o_out.motor_cmd  = w_res.motor_cmd;

endmodule

/* hw/rtl/cpid_regs.sv */
// Configuration register file for gains and clamp limits.
module cpid_regs
    import cpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output logic                  o_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_valid) begin
            unique case (i_index)
                CFG_PROP_GAIN:   r_cfg.prop_gain   <= i_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_cfg.integ_gain  <= i_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_data[GAIN_W-1:0];
                CFG_INTEG_BOUND: r_cfg.integ_bound <= i_data[BOUND_W-1:0];
                CFG_OUT_LIMIT:   r_cfg.out_limit   <= i_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/cpid_integ.sv */
// Input register, clamped error accumulator, previous error and difference stage.
module cpid_integ
    import cpid_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [ERR_W-1:0] i_err,
    input  logic                    i_clr,
    output logic                    o_ready,
    input  logic [BOUND_W-1:0]      i_bound,
    output logic                    o_valid,
    output t_stage_b                o_data,
    input  logic                    i_ready_dn
);

    logic                    r_a_valid;
    logic signed [ERR_W-1:0] r_a_err;
    logic                    r_a_clr;
    logic                    r_b_valid;
    t_stage_b                r_b;
    logic signed [ACC_W-1:0] r_accum;
    logic signed [ERR_W-1:0] r_prev;

    logic                     w_b_load;
    logic                     w_adv;
    logic signed [ACC_W-1:0]  w_base_acc;
    logic signed [ERR_W-1:0]  w_base_prev;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W:0]    w_bnd;
    logic signed [ACC_W:0]    w_clip;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [ACC_W-1:0]  n_accum;

    assign w_b_load = !r_b_valid || i_ready_dn;
    assign o_ready  = !r_a_valid || w_b_load;
    assign w_adv    = r_a_valid && w_b_load;
    assign o_valid  = r_b_valid;
    assign o_data   = r_b;

    always_comb begin
        w_base_acc  = r_a_clr ? '0 : r_accum;
        w_base_prev = r_a_clr ? '0 : r_prev;
        w_sum = {w_base_acc[ACC_W-1], w_base_acc}
              + {{(ACC_W+1-ERR_W){r_a_err[ERR_W-1]}}, r_a_err};
        w_bnd = {{(ACC_W+1-BOUND_W){1'b0}}, i_bound};
        if (w_sum > w_bnd) begin
            w_clip = w_bnd;
        end else if (w_sum < -w_bnd) begin
            w_clip = -w_bnd;
        end else begin
            w_clip = w_sum;
        end
        n_accum = w_clip[ACC_W-1:0];
        w_diff  = {r_a_err[ERR_W-1], r_a_err} - {w_base_prev[ERR_W-1], w_base_prev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_accum   <= '0;
            r_prev    <= '0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_load) begin
                r_b_valid <= r_a_valid;
            end
            if (w_adv) begin
                r_accum <= n_accum;
                r_prev  <= r_a_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_err <= i_err;
            r_a_clr <= i_clr;
        end
        if (w_adv) begin
            r_b.err  <= r_a_err;
            r_b.acc  <= n_accum;
            r_b.diff <= w_diff;
        end
    end

`ifndef SYNTHESIS
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !i_ready_dn |=> r_b_valid && $stable(r_b))
        else $error("stage B changed while stalled");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_accum) && $stable(r_prev))
        else $error("PID state changed without a transaction");
    a_prev_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_b_valid && r_prev == $past(r_a_err))
        else $error("previous error not taken from advancing sample");
`endif

endmodule

/* hw/rtl/cpid_mult.sv */
// Gain multiplier stage: three gains, integral product as two partial products.
module cpid_mult
    import cpid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_stage_b i_data,
    output logic     o_ready,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    output t_prod    o_data,
    input  logic     i_ready_dn
);

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;

    assign o_ready = !r_valid || i_ready_dn;
    assign o_valid = r_valid;
    assign o_data  = r_prod;

    always_comb begin
        n_prod.pe  = $signed(i_cfg.prop_gain) * $signed(i_data.err);
        n_prod.pd  = $signed(i_cfg.deriv_gain) * $signed(i_data.diff);
        n_prod.plo = $signed(i_cfg.integ_gain) * $signed({1'b0, i_data.acc[ACC_SPLIT-1:0]});
        n_prod.phi = $signed(i_cfg.integ_gain) * $signed(i_data.acc[ACC_W-1:ACC_SPLIT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

/* hw/rtl/cpid_out.sv */
// Product sum stage, then output clamp and motor command in the output register.
module cpid_out
    import cpid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_prod            i_data,
    output logic             o_ready,
    input  logic [LIM_W-1:0] i_limit,
    output logic             o_valid,
    output t_result          o_data,
    input  logic             i_ready_dn
);

    logic               r_d_valid;
    logic [SUM_W-1:0]   r_d_sum;
    logic               r_e_valid;
    t_result            r_e;

    logic               w_e_load;
    logic [SUM_W-1:0]   n_sum;
    logic signed [SHR_W-1:0]  w_shr;
    logic signed [SHR_W-1:0]  w_lim;
    logic signed [SHR_W-1:0]  w_clip;
    logic [CTRL_W-1:0]  w_y;
    logic [CTRL_W-1:0]  w_mag;
    logic [MOTOR_W-1:0] w_int;
    logic [MOTOR_W-1:0] w_sat;
    t_result            n_res;

    assign w_e_load = !r_e_valid || i_ready_dn;
    assign o_ready  = !r_d_valid || w_e_load;
    assign o_valid  = r_e_valid;
    assign o_data   = r_e;

    always_comb begin
        n_sum = {{(SUM_W-PE_W){i_data.pe[PE_W-1]}}, i_data.pe}
              + {{(SUM_W-PD_W){i_data.pd[PD_W-1]}}, i_data.pd}
              + {{(SUM_W-PLO_W){i_data.plo[PLO_W-1]}}, i_data.plo}
              + {{(SUM_W-PHI_W-ACC_SPLIT){i_data.phi[PHI_W-1]}}, i_data.phi,
                 {ACC_SPLIT{1'b0}}};
    end

    // drop the extra fraction bits (floor), clamp, then truncate toward zero
    always_comb begin
        w_shr = r_d_sum[SUM_W-1:FRAC_W];
        w_lim = {{(SHR_W-LIM_W){1'b0}}, i_limit};
        if (w_shr > w_lim) begin
            w_clip = w_lim;
        end else if (w_shr < -w_lim) begin
            w_clip = -w_lim;
        end else begin
            w_clip = w_shr;
        end
        w_y   = w_clip[CTRL_W-1:0];
        w_mag = w_y[CTRL_W-1] ? (~w_y + 1'b1) : w_y;
        w_int = w_mag[CTRL_W-1:FRAC_W];
        w_sat = (w_int > MOTOR_MAX) ? MOTOR_MAX : w_int;
        n_res.ctrl_value = w_y;
        n_res.motor_cmd  = w_y[CTRL_W-1] ? (~w_sat + 1'b1) : w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_d_valid <= i_valid;
            end
            if (w_e_load) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d_sum <= n_sum;
        end
        if (w_e_load && r_d_valid) begin
            r_e <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_e_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !i_ready_dn |=> r_e_valid && $stable(r_e))
        else $error("output register changed while stalled");
    a_motor_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> r_e.motor_cmd != {1'b1, {(MOTOR_W-1){1'b0}}})
        else $error("motor command outside symmetric range");
    a_motor_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !r_e.ctrl_value[CTRL_W-1] |-> !r_e.motor_cmd[MOTOR_W-1])
        else $error("motor command sign disagrees with output");
`endif

endmodule

/* tb/sv/cpid_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the clamped PID step: tracks config writes, predicts each result, compares outputs.
module cpid_result_checker
    import cpid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cpid_cfg_if  i_cfg,
    cpid_in_if   i_in,
    cpid_out_if  i_out,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam longint MOTOR_SAT = MOTOR_MAX;

    // shadow copy of the register file
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic [BOUND_W-1:0]       acc_bound;
    logic [LIM_W-1:0]         out_lim;

    // controller state
    longint err_acc;
    longint last_err;

    t_result ctrl_out_q[$];
    int      mismatch_cnt = 0;
    int      outstanding  = 0;

    assign o_fail_cnt = mismatch_cnt;
    assign o_pending  = outstanding;

    function automatic t_result pid_step(input logic signed [ERR_W-1:0] e, input logic clr);
        longint              bnd, lim, d, y, ip;
        logic signed [127:0] s, lim_w;
        t_result             r;
        bnd = acc_bound;
        lim = out_lim;
        if (clr) begin
            err_acc  = 0;
            last_err = 0;
        end
        err_acc = err_acc + e;
        if (err_acc > bnd)
            err_acc = bnd;
        if (err_acc < -bnd)
            err_acc = -bnd;
        d = e - last_err;
        // exact sum of the three products, then back to Q16.16 (floor)
        s = kp * e + ki * err_acc + kd * d;
        s = s >>> FRAC_W;
        lim_w = lim;
        if (s > lim_w)
            y = lim;
        else if (s < -lim_w)
            y = -lim;
        else
            y = $signed(s[CTRL_W-1:0]);
        last_err = e;
        // integer part, truncated toward zero
        ip = (y >= 0) ? (y >>> FRAC_W) : -((-y) >>> FRAC_W);
        if (ip > MOTOR_SAT)
            ip = MOTOR_SAT;
        if (ip < -MOTOR_SAT)
            ip = -MOTOR_SAT;
        r.ctrl_value = y[CTRL_W-1:0];
        r.motor_cmd  = ip[MOTOR_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            kp        = '0;
            ki        = '0;
            kd        = '0;
            acc_bound = '0;
            out_lim   = '0;
            err_acc   = 0;
            last_err  = 0;
            ctrl_out_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_PROP_GAIN:   kp        = i_cfg.data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:  ki        = i_cfg.data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:  kd        = i_cfg.data[GAIN_W-1:0];
                    CFG_INTEG_BOUND: acc_bound = i_cfg.data[BOUND_W-1:0];
                    CFG_OUT_LIMIT:   out_lim   = i_cfg.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                ctrl_out_q.push_back(pid_step(i_in.err_sample, i_in.clear_first));
            if (i_out.valid && i_out.ready) begin
                if (ctrl_out_q.size() == 0) begin
                    $error("result with nothing expected: ctrl_value %0d, motor_cmd %0d",
                           i_out.ctrl_value, i_out.motor_cmd);
                    mismatch_cnt++;
                end else begin
                    exp_r = ctrl_out_q.pop_front();
                    if (i_out.ctrl_value !== exp_r.ctrl_value) begin
                        $error("ctrl_value mismatch: expected %0d, got %0d",
                               exp_r.ctrl_value, i_out.ctrl_value);
                        mismatch_cnt++;
                    end
                    if (i_out.motor_cmd !== exp_r.motor_cmd) begin
                        $error("motor_cmd mismatch: expected %0d, got %0d",
                               exp_r.motor_cmd, i_out.motor_cmd);
                        mismatch_cnt++;
                    end
                end
            end
        end
        outstanding = ctrl_out_q.size();
    end

endmodule

/* tb/sv/tb_clamped_pid_step.sv */
`timescale 1ns / 1ps
// Testbench top for the clamped PID step: clock, reset, config phases, sample traffic, verdict.
module tb_clamped_pid_step;
    import cpid_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 75;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   cycle_cnt;
    int   stall_left = 0;
    bit   quiet = 1'b0;

    cpid_cfg_if cfg_ch();
    cpid_in_if  in_ch();
    cpid_out_if out_ch();

    clamped_pid_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cpid_result_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_ch),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mostly short idles, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [ERR_W-1:0] rand_err(input int drift);
        int v;
        if (drift != 0 && $urandom_range(0, 9) < 7) begin
            v = $urandom_range(0, 32'h4000_0000);
            return (drift > 0) ? v : -v;
        end
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3: begin
                v = int'($urandom_range(0, 524287)) - 262144;
                return v;
            end
            4: begin
                v = int'($urandom_range(0, 33554431)) - 16777216;
                return v;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sh0;
                    3:       return -32'sh1;
                    default: return 32'sh1;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        int v;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: begin
                v = int'($urandom_range(0, 524287)) - 262144;
                return v;
            end
            2: begin
                v = int'($urandom_range(0, 131071)) - 65536;
                return v;
            end
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [BOUND_W-1:0] rand_bound();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return w[BOUND_W-1:0];
            1:       return BOUND_W'(w[35:0]);
            2:       return BOUND_W'(w[23:0]);
            3:       return '0;
            4:       return '1;
            default: return BOUND_W'(w[31:0]);
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0, 1:    return w[LIM_W-1:0];
            2:       return '1;
            3:       return '0;
            default: return LIM_W'(w[22:0]);
        endcase
    endfunction

    // receiver side: random back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            out_ch.ready = 1'b0;
            stall_left   = gap_len() - 1;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // leaves valid high so that back-to-back samples need no extra assignment
    task automatic send_sample(input logic signed [ERR_W-1:0] e, input logic clr);
        int gap;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.err_sample  = e;
        in_ch.clear_first = clr;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    // rewrite all registers once the pipeline is empty; junk in the unused upper bits
    task automatic apply_config(input logic signed [GAIN_W-1:0] p, input logic signed [GAIN_W-1:0] i,
                                input logic signed [GAIN_W-1:0] d, input logic [BOUND_W-1:0] b,
                                input logic [LIM_W-1:0] l);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'({$urandom, $urandom});
        cfg_write(CFG_PROP_GAIN, {junk[CFG_DATA_W-1:GAIN_W], p});
        junk = CFG_DATA_W'({$urandom, $urandom});
        cfg_write(CFG_INTEG_GAIN, {junk[CFG_DATA_W-1:GAIN_W], i});
        junk = CFG_DATA_W'({$urandom, $urandom});
        cfg_write(CFG_DERIV_GAIN, {junk[CFG_DATA_W-1:GAIN_W], d});
        cfg_write(CFG_INTEG_BOUND, b);
        junk = CFG_DATA_W'({$urandom, $urandom});
        cfg_write(CFG_OUT_LIMIT, {junk[CFG_DATA_W-1:LIM_W], l});
        // unmapped index must be ignored
        if ($urandom_range(0, 1))
            cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_OUT_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'({$urandom, $urandom}));
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_clamped_pid_step NOT OK");
        $finish;
    end

    initial begin
        int drift;
        in_ch.valid       = 1'b0;
        in_ch.err_sample  = '0;
        in_ch.clear_first = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers still at reset: everything must come out zero
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);

        // kp 1.0, ki 0.5, kd -1.0, integral bound 65536.0
        apply_config(32'sh0001_0000, 32'sh0000_8000, 32'shFFFF_0000, 47'h1_0000_0000, '1);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        repeat (3) send_sample(32'sh7FFF_FFFF, 1'b0);  // runs into the positive bound
        repeat (5) send_sample(32'sh8000_0000, 1'b0);  // and over to the negative one
        send_sample(32'sh0, 1'b1);
        send_sample(32'sh1, 1'b0);
        send_sample(-32'sh1, 1'b0);
        send_sample(32'sh0001_8000, 1'b0);
        send_sample(32'shFFFE_8000, 1'b0);

        // largest gains and bounds
        apply_config(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, '1);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);

        // zero bounds: integral pinned at zero, outputs forced to zero
        apply_config(rand_gain(), rand_gain(), rand_gain(), '0, '0);
        send_sample(32'sh1234_5678, 1'b1);
        send_sample(32'shEDCB_A988, 1'b0);

        for (int p = 0; p < N_PHASES; p++) begin
            apply_config(rand_gain(), rand_gain(), rand_gain(), rand_bound(), rand_limit());
            quiet = (p % 4 == 1);
            drift = $urandom_range(0, 2) - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(rand_err(drift), $urandom_range(0, 15) == 0);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("tb_clamped_pid_step OK");
        else
            $display("tb_clamped_pid_step NOT OK");
        $finish;
    end

endmodule
